@@ src/lkvc_pkg.sv @@
// shared types and constants for the lru key-value cache
`default_nettype none

package lkvc_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam int CAPACITY_W          = 5;
   localparam int CAPACITY_RESET      = 16;
   localparam int DATA_W              = 32;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic take;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ src/lkvc_cell.sv @@
// one recency slot of the chain: holds an entry, loads its neighbor's entry on take
`default_nettype none

module lkvc_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lkvc_pkg::cell_ctl_type              ctl,
   input  wire lkvc_pkg::entry_type                 prev,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]  lookup_key,
   output lkvc_pkg::entry_type                      entry,
   output logic                                     match
);

   logic                                valid_ff;
   logic signed [lkvc_pkg::DATA_W-1:0]  key_ff;
   logic signed [lkvc_pkg::DATA_W-1:0]  value_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.take) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         key_ff   <= prev.key;
         value_ff <= prev.value;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = valid_ff && (key_ff == lookup_key);

endmodule

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// top level of the lru key-value cache: request control and the chain of recency cells
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement, kept
// as a chain of cells ordered by recency (cell 0 is the most recent). An item is
// taken when start is high and busy is low; busy then stays high for one cycle
// while the chain shifts, so the block takes no new item until the shift is done.
// The compare across all cells happens in the cycle the item is taken, the shift
// of the chain in the next one, and the result strobe rsp_valid is high for one
// cycle, registered from the update state. The receiver cannot hold results
// off. A write of csr_write_data (capacity, 0 acts as 1, above MAX_ENTRIES acts
// as MAX_ENTRIES) empties the cache in the same cycle.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_operation,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]  req_key,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]  req_value,
   output logic                                     rsp_valid,
   output logic                                     rsp_found,
   output logic signed [lkvc_pkg::DATA_W-1:0]       rsp_read_value,
   output logic                                     rsp_evicted,
   input  wire logic                                csr_write_enable,
   input  wire logic [lkvc_pkg::CAPACITY_W-1:0]     csr_write_data
);

   localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic state_ff, state_in;

   logic [lkvc_pkg::CAPACITY_W-1:0] capacity_ff;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                eff_capacity;

   logic                                operation_ff;
   logic signed [lkvc_pkg::DATA_W-1:0]  key_ff;
   logic signed [lkvc_pkg::DATA_W-1:0]  value_ff;
   logic                                hit_ff, hit_in;
   logic [POS_W-1:0]                    hit_pos_ff, hit_pos_in;
   logic signed [lkvc_pkg::DATA_W-1:0]  hit_value_ff, hit_value_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic signed [lkvc_pkg::DATA_W-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic                                rsp_evicted_ff, rsp_evicted_in;

   lkvc_pkg::entry_type entries [MAX_ENTRIES];
   lkvc_pkg::entry_type new_entry;
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES-1:0] valid_vec;
   logic                   accept;
   logic                   shift_en;
   logic [POS_W-1:0]       shift_last;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_UPDATE);

   // clamp the capacity register into 1 .. MAX_ENTRIES
   always_comb begin
      int cap;
      cap = int'(capacity_ff);
      if (cap == 0) begin
         eff_capacity = CNT_W'(1);
      end else if (cap > MAX_ENTRIES) begin
         eff_capacity = CNT_W'(MAX_ENTRIES);
      end else begin
         eff_capacity = CNT_W'(cap);
      end
   end

   // lookup against the request ports in the accept cycle; keys are unique
   always_comb begin
      hit_in       = 1'b0;
      hit_pos_in   = '0;
      hit_value_in = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_in     = 1'b1;
            hit_pos_in = POS_W'(i);
         end
         hit_value_in = hit_value_in | (match_vec[i] ? entries[i].value : '0);
      end
   end

   // decide how far down the chain entries slide toward the tail, the new count and the response
   always_comb begin
      shift_en          = 1'b0;
      shift_last        = '0;
      count_in          = count_ff;
      rsp_valid_in      = 1'b0;
      rsp_found_in      = 1'b0;
      rsp_read_value_in = '0;
      rsp_evicted_in    = 1'b0;
      new_entry.valid   = 1'b1;
      new_entry.key     = key_ff;
      new_entry.value   = (operation_ff == lkvc_pkg::OP_PUT) ? value_ff : hit_value_ff;
      if (state_ff == ST_UPDATE) begin
         rsp_valid_in = 1'b1;
         if (hit_ff) begin
            shift_en     = 1'b1;
            shift_last   = hit_pos_ff;
            rsp_found_in = 1'b1;
            if (operation_ff == lkvc_pkg::OP_GET) begin
               rsp_read_value_in = hit_value_ff;
            end
         end else if (operation_ff == lkvc_pkg::OP_PUT) begin
            shift_en = 1'b1;
            if (count_ff < eff_capacity) begin
               shift_last = POS_W'(count_ff);
               count_in   = count_ff + CNT_W'(1);
            end else begin
               // tail cell holds the least recent entry and falls off
               shift_last     = POS_W'(count_ff - CNT_W'(1));
               rsp_evicted_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= lkvc_pkg::CAPACITY_W'(lkvc_pkg::CAPACITY_RESET);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
            count_ff    <= '0;
         end else begin
            count_ff <= count_in;
         end
         if (accept) begin
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         operation_ff <= req_operation;
         key_ff       <= req_key;
         value_ff     <= req_value;
         hit_pos_ff   <= hit_pos_in;
         hit_value_ff <= hit_value_in;
      end
      rsp_found_ff      <= rsp_found_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_evicted_ff    <= rsp_evicted_in;
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lkvc_pkg::cell_ctl_type ctl;
      lkvc_pkg::entry_type    prev;

      assign ctl.clear = csr_write_enable;
      assign ctl.take  = shift_en && (POS_W'(i) <= shift_last);

      if (i == 0) begin : g_head
         assign prev = new_entry;
      end else begin : g_link
         assign prev = entries[i-1];
      end

      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev       (prev),
         .lookup_key (req_key),
         .entry      (entries[i]),
         .match      (match_vec[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   a_result_follows_update: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("update cycle not followed by a result");

   a_valid_cells_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid cells disagree with the entry count");

   a_count_within_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= eff_capacity)
      else $error("entry count above capacity");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_found)
      else $error("eviction reported together with a hit");

endmodule

`default_nettype wire

@@ test/lkvc_checker.sv @@
// result checker for the lru key-value cache: recency model, queue of predicted lookups, compare
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                req_operation,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]  req_key,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]  req_value,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_found,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]  rsp_read_value,
   input  wire logic                                rsp_evicted,
   input  wire logic                                csr_write_enable,
   input  wire logic [lkvc_pkg::CAPACITY_W-1:0]     csr_write_data,
   output int                                       mismatch_count,
   output int                                       outstanding
);

   localparam int SLOTS  = lkvc_pkg::DEFAULT_MAX_ENTRIES;
   localparam int RANK_W = $clog2(SLOTS);

   typedef struct {
      logic                              found;
      logic signed [lkvc_pkg::DATA_W-1:0] read_value;
      logic                              evicted;
   } lookup_result_type;

   logic                               slot_valid [SLOTS];
   logic [lkvc_pkg::DATA_W-1:0]        slot_key   [SLOTS];
   logic [lkvc_pkg::DATA_W-1:0]        slot_value [SLOTS];
   logic [RANK_W-1:0]                  slot_rank  [SLOTS];
   logic [lkvc_pkg::CAPACITY_W-1:0]    slot_count;
   logic [lkvc_pkg::CAPACITY_W-1:0]    capacity;
   lookup_result_type                  predicted_lookups [$];

   task automatic empty_cache();
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = '0;
      end
      slot_count = '0;
   endtask

   function automatic int usable_slots();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return int'(capacity);
   endfunction

   // entries more recent than the touched one age by one
   task automatic make_most_recent(input int slot);
      logic [RANK_W-1:0] old_rank;
      old_rank = slot_rank[slot];
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && i != slot && slot_rank[i] < old_rank)
            slot_rank[i] = slot_rank[i] + 1'b1;
      end
      slot_rank[slot] = '0;
   endtask

   task automatic access_cache(input logic op, input logic [lkvc_pkg::DATA_W-1:0] key,
                               input logic [lkvc_pkg::DATA_W-1:0] value,
                               output lookup_result_type res);
      int hit;
      int slot;
      hit = -1;
      slot = -1;
      res.found = 1'b0;
      res.read_value = '0;
      res.evicted = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && slot_key[i] == key && hit < 0) hit = i;
      end
      if (hit >= 0) begin
         res.found = 1'b1;
         if (op == lkvc_pkg::OP_PUT) slot_value[hit] = value;
         else res.read_value = slot_value[hit];
         make_most_recent(hit);
      end else if (op == lkvc_pkg::OP_PUT) begin
         if (slot_count < usable_slots()) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!slot_valid[i] && slot < 0) slot = i;
            end
         end
         if (slot >= 0) begin
            // new entry enters as least recent, then gets promoted
            slot_valid[slot] = 1'b1;
            slot_rank[slot]  = slot_count[RANK_W-1:0];
            slot_count       = slot_count + 1'b1;
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
            end
            res.evicted = 1'b1;
         end
         slot_key[slot]   = key;
         slot_value[slot] = value;
         make_most_recent(slot);
      end
   endtask

   always @(posedge clock) begin : monitor
      lookup_result_type predicted;
      if (reset) begin
         empty_cache();
         capacity = lkvc_pkg::CAPACITY_W'(lkvc_pkg::CAPACITY_RESET);
         predicted_lookups.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            capacity = csr_write_data;
            empty_cache();
         end
         if (rsp_valid) begin
            if (predicted_lookups.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("lkvc: result with nothing pending: found=%b read_value=%0d evicted=%b",
                           rsp_found, rsp_read_value, rsp_evicted);
               end
            end else begin
               predicted = predicted_lookups.pop_front();
               if (rsp_found !== predicted.found || rsp_read_value !== predicted.read_value ||
                   rsp_evicted !== predicted.evicted) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("lkvc: mismatch at %0t: expected found=%b read_value=%0d evicted=%b",
                              $realtime, predicted.found, predicted.read_value, predicted.evicted);
                     $display("lkvc:                  got found=%b read_value=%0d evicted=%b",
                              rsp_found, rsp_read_value, rsp_evicted);
                  end
               end
            end
         end
         if (start && !busy) begin
            access_cache(req_operation, req_key, req_value, predicted);
            predicted_lookups.push_back(predicted);
         end
      end
      outstanding <= predicted_lookups.size();
   end

endmodule

`default_nettype wire

@@ test/lru_key_value_cache_tb.sv @@
// top of the lru key-value cache testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_tb;

   localparam int CYCLE_LIMIT = 150000;
   localparam int POOL_MAX    = 24;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 115;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                req_operation = 1'b0;
   logic signed [lkvc_pkg::DATA_W-1:0]  req_key = '0;
   logic signed [lkvc_pkg::DATA_W-1:0]  req_value = '0;
   logic                                csr_write_enable = 1'b0;
   logic [lkvc_pkg::CAPACITY_W-1:0]     csr_write_data = '0;
   logic                                busy;
   logic                                rsp_valid;
   logic                                rsp_found;
   logic signed [lkvc_pkg::DATA_W-1:0]  rsp_read_value;
   logic                                rsp_evicted;
   int                                  mismatch_count;
   int                                  outstanding;
   int                                  cycle_count = 0;
   logic [lkvc_pkg::DATA_W-1:0]         key_pool [POOL_MAX];
   int                                  pool_size;
   int                                  capacity_plan [PHASES] = '{1, 31, 3, 8, 16, 17, 0, 5, 15, 2};

   lru_key_value_cache uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lkvc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_key_value_cache_tb: errors");
         $finish;
      end
   end

   // holds start high until the transfer happens
   task automatic send_item(input logic op, input logic [lkvc_pkg::DATA_W-1:0] key,
                            input logic [lkvc_pkg::DATA_W-1:0] value);
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(input int cap);
      start <= 1'b0;
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap[lkvc_pkg::CAPACITY_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // keys that differ from a base in one bit stress the full-width compare
   task automatic fill_key_pool(input int cap);
      int usable;
      usable = (cap == 0) ? 1 : (cap > 16) ? 16 : cap;
      pool_size = usable + $urandom_range(1, 6);
      key_pool[0] = $urandom;
      for (int i = 1; i < POOL_MAX; i++) begin
         if ($urandom_range(0, 1) == 1) key_pool[i] = $urandom;
         else key_pool[i] = key_pool[0] ^ (32'd1 << $urandom_range(0, 31));
      end
   endtask

   task automatic run_phase(input int items, input int gap_max);
      int burst_left;
      int pause_at;
      logic [lkvc_pkg::DATA_W-1:0] key;
      burst_left = $urandom_range(1, 16);
      pause_at   = $urandom_range(items / 4, 3 * items / 4);
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(0, pool_size - 1)];
         send_item($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, key, $urandom);
         burst_left--;
         if (n == pause_at) begin
            start <= 1'b0;
            drain();
            burst_left = $urandom_range(1, 16);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, gap_max)) @(posedge clock);
            end
         end
      end
      start <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: misses, fills, hits with extreme keys and values
      send_item(lkvc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_04D2);
      send_item(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lkvc_pkg::OP_GET, 32'h8000_0001, 32'h0000_0000);

      // two entries: the write clears the store, then eviction of the least recently used one
      set_capacity(2);
      send_item(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(lkvc_pkg::OP_PUT, 32'h0000_0005, 32'h0000_0050);
      send_item(lkvc_pkg::OP_PUT, 32'h0000_0006, 32'h0000_0060);
      send_item(lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);
      send_item(lkvc_pkg::OP_PUT, 32'h0000_0007, 32'h0000_0070);
      send_item(lkvc_pkg::OP_GET, 32'h0000_0006, 32'h0000_0000);
      send_item(lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);

      // zero capacity acts as one entry
      set_capacity(0);
      send_item(lkvc_pkg::OP_PUT, 32'h0000_0001, 32'h1111_1111);
      send_item(lkvc_pkg::OP_PUT, 32'h0000_0002, 32'h2222_2222);
      send_item(lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
      send_item(lkvc_pkg::OP_GET, 32'h0000_0002, 32'h0000_0000);

      for (int p = 0; p < PHASES; p++) begin
         set_capacity(capacity_plan[p]);
         fill_key_pool(capacity_plan[p]);
         run_phase(PHASE_ITEMS, (p % 3 == 1) ? 0 : 8);
      end

      start <= 1'b0;
      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("lru_key_value_cache_tb: clean");
      end else begin
         $display("lru_key_value_cache_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
